// ----- src/nnpc_pkg.sv -----
// Package for the nearest-neighbour point chain filter.
// Holds widths, register indexes and the control/status structs used by the modules.
// No dependencies.
`default_nettype none

package nnpc_pkg;

	localparam int MAX_POINTS_DEF = 32;  // default point store depth
	localparam int RESULT_CAP     = 32;  // longest chain that is reported
	localparam int COORD_W        = 16;  // signed Q8.8 coordinate
	localparam int INDEX_W        = 5;   // reported source index
	localparam int SQ_W           = 32;  // one squared axis difference
	localparam int D2_W           = 33;  // sum of two squared differences
	localparam int CMP_W          = 8;   // width for count compares

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT = 1'd1;

	localparam logic                  FILTER_ENABLE_RST  = 1'b1;
	localparam logic [CFG_DATA_W-1:0] DISTANCE_LIMIT_RST = 16'd1408;  // 5.5 m

	// controller -> datapath
	typedef struct packed {
		logic load;        // store the point of an input transfer
		logic start_set;   // latch start position, open a new chain
		logic scan_start;  // rewind the scan, forget the best candidate
		logic scan_run;    // issue reads through the candidate pipeline
		logic commit;      // append the best candidate to the chain
		logic emit;        // load the output register from the current point
		logic emit_end;    // mark the loaded result as the last one
		logic emit_empty;  // load the empty-chain result instead
		logic finish;      // close the set
	} nnpc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;   // all candidates went through the compare stage
		logic have;        // a qualifying candidate was found
		logic last_step;   // committing the candidate fills the chain
		logic len_zero;    // no point chained yet
		logic out_free;    // output register can take a result this cycle
	} nnpc_sts_t;

endpackage

`default_nettype wire

// ----- src/nnpc_in_if.sv -----
// Input channel of the point chain filter: one point per transfer.
// Depends on nnpc_pkg for the coordinate width.
`default_nettype none

interface nnpc_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [nnpc_pkg::COORD_W-1:0] point_x;
	logic signed [nnpc_pkg::COORD_W-1:0] point_y;
	logic signed [nnpc_pkg::COORD_W-1:0] start_x;
	logic signed [nnpc_pkg::COORD_W-1:0] start_y;
	logic                                set_end;

	modport source (output valid, point_x, point_y, start_x, start_y, set_end, input ready);
	modport sink   (input valid, point_x, point_y, start_x, start_y, set_end, output ready);
endinterface

`default_nettype wire

// ----- src/nnpc_out_if.sv -----
// Output channel of the point chain filter: one chained point per transfer.
// Depends on nnpc_pkg for the coordinate and index widths.
`default_nettype none

interface nnpc_out_if;
	logic                                valid;
	logic                                ready;
	logic                                valid_res;
	logic signed [nnpc_pkg::COORD_W-1:0] out_x;
	logic signed [nnpc_pkg::COORD_W-1:0] out_y;
	logic        [nnpc_pkg::INDEX_W-1:0] source_index;
	logic                                dropped;
	logic                                chain_end;

	modport source (output valid, valid_res, out_x, out_y, source_index, dropped, chain_end,
		input ready);
	modport sink   (input valid, valid_res, out_x, out_y, source_index, dropped, chain_end,
		output ready);
endinterface

`default_nettype wire

// ----- src/nnpc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nnpc_pkg for default sizes only.
`default_nettype none

module nnpc_ram #(
	parameter int WIDTH = 2 * nnpc_pkg::COORD_W,
	parameter int DEPTH = nnpc_pkg::MAX_POINTS_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

// ----- src/nnpc_ctrl.sv -----
// Sequencer of the point chain filter: load, scan, decide, emit.
// Depends on nnpc_pkg for the command and status structs.
`default_nettype none

module nnpc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_set_end,
	output logic                     in_ready,
	output nnpc_pkg::nnpc_cmd_t      cmd,
	input  wire nnpc_pkg::nnpc_sts_t sts
);
	import nnpc_pkg::*;

	localparam logic [2:0] ST_LOAD   = 3'd0;
	localparam logic [2:0] ST_STEP   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_LAST   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_set_end) begin
						cmd.start_set = 1'b1;
						state_d       = ST_STEP;
					end
				end
			end
			ST_STEP: begin
				cmd.scan_start = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.out_free) begin
					if (sts.have) begin
						// hand out the previous point, then advance
						cmd.commit = 1'b1;
						cmd.emit   = !sts.len_zero;
						state_d    = sts.last_step ? ST_LAST : ST_STEP;
					end else begin
						cmd.emit       = 1'b1;
						cmd.emit_end   = 1'b1;
						cmd.emit_empty = sts.len_zero;
						cmd.finish     = 1'b1;
						state_d        = ST_LOAD;
					end
				end
			end
			ST_LAST: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_end = 1'b1;
					cmd.finish   = 1'b1;
					state_d      = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_scan_leads_to_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_done) |=> (state_q == ST_DECIDE))
		else $error("scan completion did not reach the decision state");
`endif
endmodule

`default_nettype wire

// ----- src/nnpc_dp.sv -----
// Datapath of the point chain filter: point store, candidate pipeline, best tracker,
// chain registers, configuration registers and output register.
// Depends on nnpc_pkg and nnpc_ram.
`default_nettype none

module nnpc_dp #(
	parameter int MAX_POINTS = nnpc_pkg::MAX_POINTS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [nnpc_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [nnpc_pkg::CFG_DATA_W-1:0]      wr_data,
	input  wire logic signed [nnpc_pkg::COORD_W-1:0]  point_x,
	input  wire logic signed [nnpc_pkg::COORD_W-1:0]  point_y,
	input  wire logic signed [nnpc_pkg::COORD_W-1:0]  start_x,
	input  wire logic signed [nnpc_pkg::COORD_W-1:0]  start_y,
	input  wire logic                                 out_ready,
	output logic                                      out_valid,
	output logic                                      valid_res,
	output logic signed [nnpc_pkg::COORD_W-1:0]       out_x,
	output logic signed [nnpc_pkg::COORD_W-1:0]       out_y,
	output logic        [nnpc_pkg::INDEX_W-1:0]       source_index,
	output logic                                      dropped,
	output logic                                      chain_end,
	input  wire nnpc_pkg::nnpc_cmd_t                  cmd,
	output nnpc_pkg::nnpc_sts_t                       sts
);
	import nnpc_pkg::*;

	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int RAM_W = 2 * COORD_W;

	function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0]     df;
		logic signed [2*COORD_W+1:0] pr;
		df = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		pr = (2*COORD_W+2)'(df) * (2*COORD_W+2)'(df);
		return pr[SQ_W-1:0];
	endfunction

	// configuration
	logic                  fe_q;
	logic [CFG_DATA_W-1:0] dl_q;
	logic [SQ_W-1:0]       lim2_q;

	// set bookkeeping
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          full;

	// scan
	logic [CW-1:0]    j_q;
	logic             issue;
	logic [RAM_W-1:0] rdata;
	logic signed [COORD_W-1:0] rx;
	logic signed [COORD_W-1:0] ry;

	logic          vld_s1, used_s1;
	logic [AW-1:0] j_s1;

	logic                      vld_s2, used_s2;
	logic [AW-1:0]             j_s2;
	logic signed [COORD_W-1:0] x_s2, y_s2;
	logic [SQ_W-1:0]           sqdx_s2, sqdy_s2, sqex_s2, sqey_s2;

	logic                      vld_s3, used_s3;
	logic [AW-1:0]             j_s3;
	logic signed [COORD_W-1:0] x_s3, y_s3;
	logic [D2_W-1:0]           d_s3, l3_s3;
	logic [D2_W:0]             l1d_s3;

	logic qual, upd;

	// best candidate of the running scan
	logic                      have_q;
	logic [AW-1:0]             best_j_q;
	logic [D2_W-1:0]           bestd_q;
	logic signed [COORD_W-1:0] best_x_q, best_y_q;

	// chain
	logic signed [COORD_W-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic [AW-1:0]             cur_j_q;
	logic [D2_W-1:0]           l1_q;
	logic [CW-1:0]             len_q;
	logic [MAX_POINTS-1:0]     used_q;

	// output register
	logic                      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q <= FILTER_ENABLE_RST;
			dl_q <= DISTANCE_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_FILTER_ENABLE:  fe_q <= wr_data[0];
				REG_DISTANCE_LIMIT: dl_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lim2_q <= SQ_W'(dl_q) * SQ_W'(dl_q);
	end

	assign full = (count_q == CW'(MAX_POINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.finish) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	nnpc_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (cmd.load && !full),
		.waddr(count_q[AW-1:0]),
		.wdata({point_x, point_y}),
		.raddr(j_q[AW-1:0]),
		.rdata(rdata)
	);

	assign issue = cmd.scan_run && (j_q != count_q);
	assign rx    = rdata[RAM_W-1:COORD_W];
	assign ry    = rdata[COORD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q    <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				j_q <= '0;
			end else if (issue) begin
				j_q <= j_q + CW'(1);
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// read -> square -> sum; compare in front of the best registers
	always_ff @(posedge clk) begin
		j_s1    <= j_q[AW-1:0];
		used_s1 <= used_q[j_q[AW-1:0]];

		j_s2    <= j_s1;
		used_s2 <= used_s1;
		x_s2    <= rx;
		y_s2    <= ry;
		sqdx_s2 <= sq_diff(rx, cur_x_q);
		sqdy_s2 <= sq_diff(ry, cur_y_q);
		sqex_s2 <= sq_diff(rx, prev_x_q);
		sqey_s2 <= sq_diff(ry, prev_y_q);

		j_s3    <= j_s2;
		used_s3 <= used_s2;
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		d_s3    <= D2_W'(sqdx_s2) + D2_W'(sqdy_s2);
		l3_s3   <= D2_W'(sqex_s2) + D2_W'(sqey_s2);
		l1d_s3  <= (D2_W+1)'(l1_q) + (D2_W+1)'(sqdx_s2) + (D2_W+1)'(sqdy_s2);
	end

	// forward test applies from the third chain point on
	assign qual = vld_s3 && !used_s3 &&
		(!fe_q || ((d_s3 < D2_W'(lim2_q)) &&
		((len_q < CW'(2)) || (l1d_s3 < (D2_W+1)'(l3_s3)))));
	assign upd  = qual && (!have_q || (d_s3 < bestd_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.scan_start) begin
			have_q <= 1'b0;
		end else if (upd) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			best_j_q <= j_s3;
			bestd_q  <= d_s3;
			best_x_q <= x_s3;
			best_y_q <= y_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			used_q <= '0;
		end else if (cmd.start_set || cmd.finish) begin
			len_q  <= '0;
			used_q <= '0;
		end else if (cmd.commit) begin
			len_q            <= len_q + CW'(1);
			used_q[best_j_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else if (cmd.start_set) begin
			cur_x_q <= start_x;
			cur_y_q <= start_y;
		end else if (cmd.commit) begin
			cur_x_q <= best_x_q;
			cur_y_q <= best_y_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
			cur_j_q  <= best_j_q;
			l1_q     <= bestd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			valid_res    <= !cmd.emit_empty;
			out_x        <= cmd.emit_empty ? '0 : cur_x_q;
			out_y        <= cmd.emit_empty ? '0 : cur_y_q;
			source_index <= cmd.emit_empty ? '0 : INDEX_W'(cur_j_q);
			dropped      <= ovf_q;
			chain_end    <= cmd.emit_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.scan_done = (j_q == count_q) && !vld_s1 && !vld_s2 && !vld_s3;
	assign sts.have      = have_q;
	assign sts.len_zero  = (len_q == '0);
	assign sts.last_step = ((CMP_W'(len_q) + CMP_W'(1)) == CMP_W'(count_q)) ||
		((CMP_W'(len_q) + CMP_W'(1)) == CMP_W'(RESULT_CAP));
	assign sts.out_free  = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded over one that was not transferred");
	a_commit_needs_best: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> have_q)
		else $error("chain advanced without a qualifying candidate");
	a_used_matches_len: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(len_q))
		else $error("used mask out of step with chain length");
	a_len_within_set: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= count_q)
		else $error("chain longer than the stored set");
`endif
endmodule

`default_nettype wire

// ----- src/nearest_neighbour_point_chain_filter.sv -----
// Flow: point items are taken back to back while a set loads; a set_end item starts ordering,
//   and each chain step scans all n stored points through a read/square/sum/compare pipeline.
// Ordering: no new points are taken until the set is done; ordering is bounded by the single
//   store read port, and results leave one per step as the chain grows when the output is free.
// Reset: arst_n clears control state, the set, the chain and the output register at once,
//   loads filter_enable = 1 and distance_limit = 1408; the point store needs no clearing.
`default_nettype none

module nearest_neighbour_point_chain_filter #(
	parameter int MAX_POINTS = nnpc_pkg::MAX_POINTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [nnpc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [nnpc_pkg::CFG_DATA_W-1:0] wr_data,
	nnpc_in_if.sink                              points,
	nnpc_out_if.source                           chain
);
	import nnpc_pkg::*;

	nnpc_cmd_t cmd;
	nnpc_sts_t sts;

	// The controller takes points while loading a set; the set_end transfer
	// latches the start position and hands over to the ordering loop:
	// scan every stored point, keep the nearest qualifying one (lowest index
	// on ties), append it, repeat. Each chained point goes out one step late,
	// so the last one can carry chain_end once the chain is known to stop.
	nnpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (points.valid),
		.in_set_end(points.set_end),
		.in_ready  (points.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath owns the store, the candidate pipeline and the output
	// register; distances are compared squared so no root is ever taken.
	nnpc_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.point_x     (points.point_x),
		.point_y     (points.point_y),
		.start_x     (points.start_x),
		.start_y     (points.start_y),
		.out_ready   (chain.ready),
		.out_valid   (chain.valid),
		.valid_res   (chain.valid_res),
		.out_x       (chain.out_x),
		.out_y       (chain.out_y),
		.source_index(chain.source_index),
		.dropped     (chain.dropped),
		.chain_end   (chain.chain_end),
		.cmd         (cmd),
		.sts         (sts)
	);
endmodule

`default_nettype wire
